// ----- sv/cbpg_pkg.sv -----
// ----------------------------------------------------------------------------
// cbpg_pkg
// shared constants, types and sequencer codes of the cubic bezier generator
// ----------------------------------------------------------------------------
package cbpg_pkg;

    // coordinate and curve parameter formats
    localparam int COORD_BITS  = 24;  // signed q15.8 coordinates
    localparam int T_FRAC_BITS = 16;  // fractional bits of t
    localparam int NUM_CTRL    = 12;  // four points, three axes
    localparam int NUM_AXES    = 3;
    localparam int SEG_W       = 6;   // segment count width

    localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(63);

    // t, 1-t and all weights fit in q1.T
    localparam int TW      = T_FRAC_BITS + 1;
    // quotient of 2^(T+1) / (2n) and its bit counter
    localparam int QW      = T_FRAC_BITS + 2;
    localparam int QCNT_W  = $clog2(QW);
    // divisor 2n and remainder widths
    localparam int DW      = SEG_W + 1;
    localparam int REM_W   = SEG_W + 2;

    // shared multiplier operands, product and accumulator
    localparam int MA_W    = TW + 1;
    localparam int MB_W    = ((COORD_BITS > TW) ? COORD_BITS : TW) + 1;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int SC_W    = PROD_W + 2;

    localparam int CIDX_W  = $clog2(NUM_CTRL);

    // stream payload widths
    localparam int IN_W        = NUM_CTRL * COORD_BITS;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = NUM_AXES * COORD_BITS;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

    // operation codes of the sequencer, one multiply each
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_MT2         = OP_W'(0);  // (1-t)^2
    localparam logic [OP_W-1:0] OP_T2          = OP_W'(1);  // t^2
    localparam logic [OP_W-1:0] OP_W0          = OP_W'(2);  // (1-t)^3
    localparam logic [OP_W-1:0] OP_W1          = OP_W'(3);  // 3(1-t)^2 t
    localparam logic [OP_W-1:0] OP_W2          = OP_W'(4);  // 3(1-t) t^2
    localparam logic [OP_W-1:0] OP_W3          = OP_W'(5);  // t^3
    localparam logic [OP_W-1:0] OP_BLEND_FIRST = OP_W'(6);  // weight times coordinate
    localparam logic [OP_W-1:0] OP_LAST        = OP_W'(17);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_USE,
        S_EMIT
    } t_state;

    // control from the sequencer to the t stepper
    typedef struct packed {
        logic start;
        logic advance;
    } t_tstep_ctl;

    // request to the shared multiplier
    typedef struct packed {
        logic                   en;
        logic signed [MA_W-1:0] a;
        logic signed [MB_W-1:0] b;
    } t_mul_req;

endpackage

// ----- sv/cubic_bezier_point_generator.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_point_generator
// emits the n+1 points of a cubic bezier curve at t = i/n from four 3d points
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                      payload
// --------  ---------  -----------------------------  -------------------------
// s_axis    in         s_axis_tvalid / s_axis_tready  p0..p3 x,y,z, 24 b each
// m_axis    out        m_axis_tvalid / m_axis_tready  curve x,y,z; tlast = t=1
// cfg       in         i_cfg_valid / o_cfg_ready      segment count n (6 b)
//
// one request, accept to accept with no stall, runs through the idle state,
// then bit-serial division for the t step, then per point 18 products on
// the shared multiplier, each a multiply step and a use step, plus one load
// s_axis_tready is high only when no request is in work
// a stalled m_axis holds the sequencer in its emit step, nothing is dropped
// reset is synchronous, active low; segment count resets to 63, 0 acts as 1
//
module cubic_bezier_point_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
    input  logic [cbpg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // curve_x, curve_y, curve_z
    output logic [cbpg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cbpg_pkg::SEG_W-1:0]          i_cfg_data
);
    import cbpg_pkg::*;

    // saturation bounds of a coordinate, at accumulator width
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
    localparam logic [SC_W-1:0] HALF_SC = SC_W'(1) << (T_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(1) << (T_FRAC_BITS - 1);

    // sequencer and control registers
    t_state                  r_state, n_state;
    logic [SEG_W-1:0]        r_seg_cnt;
    logic [SEG_W-1:0]        r_idx;
    logic [OP_W-1:0]         r_op;
    logic                    r_out_valid;

    // payload registers
    logic signed [COORD_BITS-1:0] r_ctrl [NUM_CTRL];
    logic [SEG_W-1:0]        r_n;
    logic [TW-1:0]           r_mt2;
    logic [TW-1:0]           r_t2;
    logic [TW-1:0]           r_w [4];
    logic signed [ACC_W-1:0] r_acc;
    logic signed [COORD_BITS-1:0] r_res [NUM_AXES];
    logic [OUT_W-1:0]        r_out_data;
    logic                    r_out_last;

    // control strobes from the output decode
    logic                    w_in_acc;
    logic                    w_out_free;
    logic                    w_use_en;
    logic                    w_load_out;
    logic                    w_is_last;
    t_tstep_ctl              w_tctl;
    t_mul_req                w_mreq;

    logic [SEG_W-1:0]        w_n_eff;
    logic [TW-1:0]           w_t;
    logic                    w_t_ready;
    logic [TW-1:0]           w_mt;
    logic signed [PROD_W-1:0] w_prod;

    // blend decode: which control point and axis
    logic [OP_W-1:0]         w_j;
    logic [1:0]              w_k;
    logic [1:0]              w_axis;
    logic [CIDX_W-1:0]       w_cidx;

    // product post-processing
    logic [SC_W-1:0]         w_p;
    logic [SC_W-1:0]         w_scaled;
    logic [SC_W-1:0]         w_rnd;
    logic [TW-1:0]           w_weight;
    logic signed [ACC_W-1:0] w_sum;
    logic signed [ACC_W-1:0] w_q;
    logic signed [COORD_BITS-1:0] w_sat;

    // ------------------------------------------------------------------
    // shared units
    // ------------------------------------------------------------------
    cbpg_tstep u_tstep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_tctl),
        .i_n     (w_n_eff),
        .o_t     (w_t),
        .o_ready (w_t_ready)
    );

    cbpg_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mreq),
        .o_prod (w_prod)
    );

    // ------------------------------------------------------------------
    // datapath decode
    // ------------------------------------------------------------------
    assign w_n_eff = (r_seg_cnt == '0) ? SEG_W'(1) : r_seg_cnt;
    assign w_mt    = T_ONE - w_t;

    always_comb begin
        w_j    = r_op - OP_BLEND_FIRST;
        w_axis = w_j[3:2];
        w_k    = w_j[1:0];
        // point k, axis a sits at k*3 + a
        w_cidx = CIDX_W'({2'b00, w_k} + {1'b0, w_k, 1'b0} + {2'b00, w_axis});
    end

    // weight ops: product is nonnegative, times 3 for the middle weights,
    // then rounded back to q1.T
    always_comb begin
        w_p = SC_W'(unsigned'(w_prod));
        if (r_op == OP_W1 || r_op == OP_W2) begin
            w_scaled = w_p + (w_p << 1);
        end else begin
            w_scaled = w_p;
        end
        w_rnd    = w_scaled + HALF_SC;
        w_weight = w_rnd[T_FRAC_BITS +: TW];
    end

    // blend ops: rounding half is folded in with the first product
    always_comb begin
        w_sum = ((w_k == 2'd0) ? HALF_ACC : r_acc) + ACC_W'(w_prod);
        w_q   = w_sum >>> T_FRAC_BITS;
        if (w_q > SAT_HI) begin
            w_sat = SAT_HI[COORD_BITS-1:0];
        end else if (w_q < SAT_LO) begin
            w_sat = SAT_LO[COORD_BITS-1:0];
        end else begin
            w_sat = w_q[COORD_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_t_ready) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_USE;
            end
            S_USE: begin
                if (r_op == OP_LAST) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = (r_idx == r_n) ? S_IDLE : S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_axis_tready  = 1'b0;
        w_use_en       = 1'b0;
        w_load_out     = 1'b0;
        w_mreq.en      = 1'b0;
        w_mreq.a       = '0;
        w_mreq.b       = '0;
        w_out_free     = !r_out_valid || m_axis_tready;
        w_is_last      = (r_idx == r_n);
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_MUL: begin
                w_mreq.en = 1'b1;
            end
            S_USE: begin
                w_use_en = 1'b1;
            end
            S_EMIT: begin
                w_load_out = w_out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase

        // operand select per op code
        case (r_op)
            OP_MT2: begin
                w_mreq.a = $signed({1'b0, w_mt});
                w_mreq.b = $signed(MB_W'({1'b0, w_mt}));
            end
            OP_T2: begin
                w_mreq.a = $signed({1'b0, w_t});
                w_mreq.b = $signed(MB_W'({1'b0, w_t}));
            end
            OP_W0: begin
                w_mreq.a = $signed({1'b0, r_mt2});
                w_mreq.b = $signed(MB_W'({1'b0, w_mt}));
            end
            OP_W1: begin
                w_mreq.a = $signed({1'b0, r_mt2});
                w_mreq.b = $signed(MB_W'({1'b0, w_t}));
            end
            OP_W2: begin
                w_mreq.a = $signed({1'b0, w_mt});
                w_mreq.b = $signed(MB_W'({1'b0, r_t2}));
            end
            OP_W3: begin
                w_mreq.a = $signed({1'b0, r_t2});
                w_mreq.b = $signed(MB_W'({1'b0, w_t}));
            end
            default: begin
                w_mreq.a = $signed({1'b0, r_w[w_k]});
                w_mreq.b = MB_W'(r_ctrl[w_cidx]);
            end
        endcase

        w_in_acc       = s_axis_tvalid && s_axis_tready;
        w_tctl.start   = w_in_acc;
        w_tctl.advance = w_load_out && !w_is_last;
    end

    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seg_cnt   <= SEG_RESET;
            r_idx       <= '0;
            r_op        <= OP_MT2;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_seg_cnt <= i_cfg_data;
            end
            if (w_in_acc) begin
                r_idx <= '0;
                r_op  <= OP_MT2;
            end else begin
                if (w_use_en) begin
                    r_op <= (r_op == OP_LAST) ? OP_MT2 : (r_op + OP_W'(1));
                end
                if (w_tctl.advance) begin
                    r_idx <= r_idx + SEG_W'(1);
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            for (int i = 0; i < NUM_CTRL; i++) begin
                r_ctrl[i] <= s_axis_tdata[i*COORD_BITS +: COORD_BITS];
            end
            r_n <= w_n_eff;
        end
        if (w_use_en) begin
            case (r_op)
                OP_MT2: r_mt2  <= w_weight;
                OP_T2:  r_t2   <= w_weight;
                OP_W0:  r_w[0] <= w_weight;
                OP_W1:  r_w[1] <= w_weight;
                OP_W2:  r_w[2] <= w_weight;
                OP_W3:  r_w[3] <= w_weight;
                default: begin
                    r_acc <= w_sum;
                    if (w_k == 2'd3) begin
                        r_res[w_axis] <= w_sat;
                    end
                end
            endcase
        end
        if (w_load_out) begin
            r_out_data <= {r_res[2], r_res[1], r_res[0]};
            r_out_last <= w_is_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_data);
    assign m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_DIV && r_idx == '0 && r_op == OP_MT2))
        else $error("request accept did not restart the sequencer");

    a_stepper_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> w_t_ready)
        else $error("multiply issued while t step division still running");

    a_t_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_op == OP_MT2 && r_idx == '0) |-> (w_t == '0))
        else $error("first point not at t equal to zero");

    a_t_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_op == OP_MT2 && r_idx == r_n) |-> (w_t == T_ONE))
        else $error("last point not at t equal to one");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_DIV) |-> (r_idx <= r_n))
        else $error("point index ran past the segment count");

endmodule

// ----- sv/cbpg_mul.sv -----
// ----------------------------------------------------------------------------
// cbpg_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module cbpg_mul (
    input  logic                                 i_clk,
    input  cbpg_pkg::t_mul_req                   i_req,
    output logic signed [cbpg_pkg::PROD_W-1:0]   o_prod
);
    import cbpg_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;

    always_comb begin
        n_prod = PROD_W'(i_req.a) * PROD_W'(i_req.b);
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- sv/cbpg_tstep.sv -----
// ----------------------------------------------------------------------------
// cbpg_tstep
// curve parameter stepper: t = round(i * 2^T / n) by exact increments
// ----------------------------------------------------------------------------
module cbpg_tstep (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cbpg_pkg::t_tstep_ctl              i_ctl,
    input  logic [cbpg_pkg::SEG_W-1:0]        i_n,
    output logic [cbpg_pkg::TW-1:0]           o_t,
    output logic                              o_ready
);
    import cbpg_pkg::*;

    // divider state
    logic              r_busy,     n_busy;
    logic [QCNT_W-1:0] r_cnt,      n_cnt;
    logic [REM_W-1:0]  r_div_rem,  n_div_rem;
    logic [QW-1:0]     r_quot,     n_quot;
    logic [DW-1:0]     r_d,        n_d;
    // stepper state
    logic [TW-1:0]     r_t,        n_t;
    logic [DW-1:0]     r_r,        n_r;

    logic              w_a_bit;
    logic [REM_W-1:0]  w_rem_sh;
    logic              w_qbit;
    logic [REM_W-1:0]  w_r_sum;
    logic              w_wrap;

    always_comb begin
        // dividend is 2^(T+1): one bit set at the top
        w_a_bit  = (r_cnt == QCNT_W'(QW - 1));
        w_rem_sh = {r_div_rem[REM_W-2:0], w_a_bit};
        w_qbit   = (w_rem_sh >= REM_W'(r_d));

        // remainder plus remainder step stays below twice the divisor
        w_r_sum  = REM_W'(r_r) + REM_W'(r_div_rem);
        w_wrap   = (w_r_sum >= REM_W'(r_d));

        n_busy    = r_busy;
        n_cnt     = r_cnt;
        n_div_rem = r_div_rem;
        n_quot    = r_quot;
        n_d       = r_d;
        n_t       = r_t;
        n_r       = r_r;

        if (i_ctl.start) begin
            n_busy    = 1'b1;
            n_cnt     = QCNT_W'(QW - 1);
            n_div_rem = '0;
            n_d       = {i_n, 1'b0};
            n_t       = '0;
            n_r       = DW'(i_n);
        end else if (r_busy) begin
            n_div_rem = w_qbit ? (w_rem_sh - REM_W'(r_d)) : w_rem_sh;
            n_quot    = {r_quot[QW-2:0], w_qbit};
            n_cnt     = r_cnt - QCNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
        end else if (i_ctl.advance) begin
            if (w_wrap) begin
                n_r = DW'(w_r_sum - REM_W'(r_d));
                n_t = r_t + r_quot[TW-1:0] + TW'(1);
            end else begin
                n_r = DW'(w_r_sum);
                n_t = r_t + r_quot[TW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_div_rem <= n_div_rem;
        r_quot    <= n_quot;
        r_d       <= n_d;
        r_t       <= n_t;
        r_r       <= n_r;
    end

    assign o_t     = r_t;
    assign o_ready = !r_busy;

endmodule

// ----- verif/cubic_bezier_point_generator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_point_generator_test
// self-checking bench for the cubic bezier point generator
// ----------------------------------------------------------------------------
// control point requests go in on s_axis, and a bit-exact fixed point
// predictor queues the n+1 curve points expected for each accepted request.
// every m_axis beat is compared against the oldest queued point. both
// streams idle at random, and the segment count is rewritten between phases
// while the block is empty.
// ----------------------------------------------------------------------------
module cubic_bezier_point_generator_test;
    import cbpg_pkg::*;

    localparam int  CLK_HALF    = 5;
    localparam int  SETTLE      = 40;         // about one point time of the block
    localparam int  RANDOM_REQS = 355;
    localparam longint LIMIT    = 4_000_000;  // cycles

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   last;
    } t_curve_point;

    localparam t_coord C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // curve_x, curve_y, curve_z
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [SEG_W-1:0]       i_cfg_data = '0;

    t_curve_point           curve_q[$];       // points still owed by the block
    logic [SEG_W-1:0]       seg_count;        // predictor copy of the register
    int                     mismatches = 0;
    bit                     no_idle = 1'b0;   // phase without gaps or stalls
    longint                 cycles = 0;
    t_curve_point           want_pt;

    cubic_bezier_point_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // back to q1.T, rounding half up
    function automatic longint round_t(input longint v);
        return (v + (longint'(1) << (T_FRAC_BITS - 1))) >>> T_FRAC_BITS;
    endfunction

    // queue every point of the curve that a request produces
    function automatic void predict_curve(input logic [IN_TDATA_W-1:0] payload);
        longint       n;
        longint       one;
        longint       t;
        longint       mt;
        longint       mt2;
        longint       t2;
        longint       acc;
        longint       w[4];
        longint       ctrl[NUM_CTRL];
        longint       hi;
        longint       lo;
        t_coord       axis_val[NUM_AXES];
        t_curve_point pt;
        n   = (seg_count == 0) ? 1 : longint'(seg_count);   // zero acts as one
        one = longint'(1) << T_FRAC_BITS;
        hi  = (longint'(1) << (COORD_BITS - 1)) - 1;
        lo  = -hi - 1;
        for (int k = 0; k < NUM_CTRL; k++) begin
            ctrl[k] = longint'($signed(payload[k*COORD_BITS +: COORD_BITS]));
        end
        for (longint i = 0; i <= n; i++) begin
            // exact t = i/n rounded to q1.T
            t    = (i * one * 2 + n) / (2 * n);
            mt   = one - t;
            mt2  = round_t(mt * mt);
            t2   = round_t(t * t);
            w[0] = round_t(mt2 * mt);
            w[1] = round_t(3 * mt2 * t);
            w[2] = round_t(3 * mt * t2);
            w[3] = round_t(t2 * t);
            for (int a = 0; a < NUM_AXES; a++) begin
                acc = 0;
                for (int k = 0; k < 4; k++) begin
                    acc += w[k] * ctrl[k*NUM_AXES + a];
                end
                // floor after adding half: nearest, ties toward plus infinity
                acc = (acc + (longint'(1) << (T_FRAC_BITS - 1))) >>> T_FRAC_BITS;
                if (acc > hi) acc = hi;
                if (acc < lo) acc = lo;
                axis_val[a] = t_coord'(acc);
            end
            pt.x    = axis_val[0];
            pt.y    = axis_val[1];
            pt.z    = axis_val[2];
            pt.last = (i == n);
            curve_q.insert(curve_q.size(), pt);
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // every axis of point k gets the k-th value
    function automatic logic [IN_TDATA_W-1:0] controls_of(input t_coord p0, p1, p2, p3);
        logic [IN_TDATA_W-1:0] payload;
        t_coord                pts[4];
        payload = '0;
        pts = '{p0, p1, p2, p3};
        for (int k = 0; k < NUM_CTRL; k++) begin
            payload[k*COORD_BITS +: COORD_BITS] = pts[k / NUM_AXES];
        end
        return payload;
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 9))
            0: return C_MAX;
            1: return C_MIN;
            2: return '0;
            3: return t_coord'(int'($urandom_range(0, 1023)) - 512);
            default: return t_coord'($urandom());
        endcase
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_controls();
        logic [IN_TDATA_W-1:0] payload;
        payload = '0;
        for (int k = 0; k < NUM_CTRL; k++) begin
            payload[k*COORD_BITS +: COORD_BITS] = rand_coord();
        end
        return payload;
    endfunction

    // one request on s_axis, predicted once accepted
    task automatic send_controls(input logic [IN_TDATA_W-1:0] payload);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= payload;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        predict_curve(payload);
    endtask

    // stop sending and wait until every owed point is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (curve_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // only called with the block empty
    task automatic write_segments(input logic [SEG_W-1:0] n);
        i_cfg_data  <= n;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        seg_count = n;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // segment count straight out of reset, extremes of every field
    task automatic test_reset_segments();
        send_controls(controls_of(C_MAX, C_MAX, C_MAX, C_MAX));
        send_controls(controls_of(C_MIN, C_MIN, C_MIN, C_MIN));
        drain();
    endtask

    // zero segments behave as one: only the end points come out
    task automatic test_zero_segments();
        write_segments('0);
        send_controls(controls_of(C_MIN, C_MAX, C_MAX, C_MAX));
        send_controls(random_controls());
        send_controls(random_controls());
        drain();
    endtask

    task automatic test_one_segment();
        write_segments(SEG_W'(1));
        send_controls(controls_of(C_MAX, C_MIN, C_MIN, C_MIN));
        send_controls(controls_of('0, '0, '0, '0));
        send_controls(random_controls());
        drain();
    endtask

    // opposing extremes push the sum toward saturation, bit patterns
    task automatic test_extremes();
        write_segments(SEG_W'(4));
        send_controls(controls_of(C_MAX, C_MIN, C_MIN, C_MAX));
        send_controls(controls_of(C_MIN, C_MAX, C_MAX, C_MIN));
        send_controls(controls_of(C_MAX, C_MAX, C_MIN, C_MIN));
        send_controls(controls_of(t_coord'(-1), t_coord'(-1), t_coord'(1), t_coord'(1)));
        send_controls(controls_of(t_coord'(24'hAAAAAA), t_coord'(24'h555555),
                                  t_coord'(24'h555555), t_coord'(24'hAAAAAA)));
        send_controls(controls_of(t_coord'(24'h555555), t_coord'(24'hAAAAAA),
                                  t_coord'(24'hAAAAAA), t_coord'(24'h555555)));
        drain();
    endtask

    task automatic test_full_segments();
        write_segments(SEG_W'(63));
        send_controls(controls_of(C_MAX, C_MAX, C_MAX, C_MAX));
        send_controls(random_controls());
        drain();
    endtask

    // phases with a fresh segment count each, mostly short curves
    task automatic test_random_curves();
        int               sent;
        int               batch;
        logic [SEG_W-1:0] n;
        sent = 0;
        while (sent < RANDOM_REQS) begin
            if ($urandom_range(0, 7) == 0) begin
                n     = $urandom_range(0, 1) ? SEG_W'(63) : SEG_W'($urandom_range(32, 63));
                batch = 2;
            end else begin
                n     = SEG_W'($urandom_range(0, 15));
                batch = $urandom_range(5, 15);
            end
            write_segments(n);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (batch) send_controls(random_controls());
            sent += batch;
            drain();
            no_idle = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // downstream stall drawn per point
    initial begin
        int stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic check_coord(input string name, input t_coord want, input t_coord got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (curve_q.size() == 0) begin
                $error("curve point: expected none, got x %0d y %0d z %0d last %0b",
                       $signed(m_axis_tdata[0 +: COORD_BITS]),
                       $signed(m_axis_tdata[COORD_BITS +: COORD_BITS]),
                       $signed(m_axis_tdata[2*COORD_BITS +: COORD_BITS]), m_axis_tlast);
                mismatches++;
            end else begin
                want_pt = curve_q.pop_front();
                check_coord("curve_x", want_pt.x, m_axis_tdata[0 +: COORD_BITS]);
                check_coord("curve_y", want_pt.y, m_axis_tdata[COORD_BITS +: COORD_BITS]);
                check_coord("curve_z", want_pt.z, m_axis_tdata[2*COORD_BITS +: COORD_BITS]);
                if (m_axis_tlast !== want_pt.last) begin
                    $error("last_point: expected %0b, got %0b", want_pt.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        seg_count = SEG_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_segments();
        test_zero_segments();
        test_one_segment();
        test_extremes();
        test_full_segments();
        test_random_curves();

        // leftovers in the queue count as failures too
        if (curve_q.size() != 0) begin
            $error("curve point: %0d expected, got none", curve_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
